// File: hdl/lcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants of the longest common substring core
// Holds the store geometry, command and result codes, the beat payload
// structs and the sequencer state encoding.
// ----------------------------------------------------------------------------
package lcs_pkg;

   // Store geometry.
   localparam int MAX_LEN   = 32;
   localparam int ELEM_BITS = 32;
   localparam int IDX_BITS  = $clog2(MAX_LEN);
   localparam int CNT_BITS  = $clog2(MAX_LEN + 1);

   typedef logic [ELEM_BITS-1:0] elem_type;
   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [CNT_BITS-1:0]  count_type;

   // Request commands.
   localparam logic [1:0] CMD_FIRST   = 2'd0;
   localparam logic [1:0] CMD_SECOND  = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;

   // Result kinds.
   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_ELEMENT = 1'b1;

   // Request beat.
   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] value;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic               kind;
      logic [5:0]         match_length;
      logic [4:0]         end_index;
      logic signed [31:0] element;
      logic               overflow;
      logic               last;
   } rsp_type;

   // Output of the shared cell unit.
   typedef struct packed {
      count_type len;
      count_type carry;
      logic      better;
   } cell_result_type;

   // Sequencer states.
   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_READ    = 6'b000010,
      ST_CALC    = 6'b000100,
      ST_SUMMARY = 6'b001000,
      ST_EL_READ = 6'b010000,
      ST_EL_OUT  = 6'b100000
   } state_type;

endpackage
`default_nettype wire

// File: hdl/lcs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lcs_ram #(
   parameter int DATA_BITS = 32,
   parameter int ADDR_BITS = 5
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: hdl/lcs_cell_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_cell_unit: shared dynamic-program cell
// Compares one element pair, forms the new run length from the diagonal
// neighbor and checks it against the best length so far.
// ----------------------------------------------------------------------------
module lcs_cell_unit (
   input  wire lcs_pkg::elem_type        first_elem,
   input  wire lcs_pkg::elem_type        second_elem,
   input  wire lcs_pkg::count_type       diag,
   input  wire lcs_pkg::count_type       above,
   input  wire logic                     top_row,
   input  wire lcs_pkg::count_type       best,
   output lcs_pkg::cell_result_type      result
);
   import lcs_pkg::*;

   count_type len;

   // New run length: extend the diagonal run on a match, else restart.
   always_comb begin
      if (first_elem == second_elem) begin
         len = diag + count_type'(1);
      end else begin
         len = '0;
      end
   end

   // The row above is all zeros while the first row is worked.
   always_comb begin
      result.len    = len;
      result.carry  = top_row ? '0 : above;
      result.better = (len > best);
   end

endmodule
`default_nettype wire

// File: hdl/longest_common_substring_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// longest_common_substring_core: longest common contiguous run of two lists
// Loads two element lists and finds their longest common substring with a
// row-by-row dynamic program on one shared compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken when start is high and busy is low. Command
//   CMD_FIRST or CMD_SECOND appends req_data.value to the first or second
//   store, so loads stream one beat per cycle. An append to a full store is
//   dropped and sets the sticky overflow flag. CMD_COMPUTE runs the dynamic
//   program: each cell passes through a RAM read state, then a compare and
//   write-back state, and the summary beat follows the last cell, or follows
//   the compute beat directly if either list is empty. The cell loop runs on
//   the shared unit with registered reads of the stores and the row RAM.
//   With emit_elements set, each matched element follows in its own beat,
//   through a store read state and then an output state. busy stays high
//   from the compute beat until the cycle after the beat marked last.
//   Result beats hold for exactly one cycle under rsp_strobe; the receiver
//   cannot stall them. The csr_ port writes emit_elements; the user must do
//   so only while idle, as the block itself does not enforce this.
//   Reset empties both stores, clears overflow and sets emit_elements.
// ----------------------------------------------------------------------------
module longest_common_substring_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire lcs_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output lcs_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_write_data
);
   import lcs_pkg::*;

   state_type       state_ff, state_in;
   idx_type         row_ff, row_in;
   idx_type         col_ff, col_in;
   idx_type         elem_ff, elem_in;
   count_type       best_ff, best_in;
   idx_type         end_ff, end_in;
   count_type       diag_ff, diag_in;
   count_type       first_count_ff, first_count_in;
   count_type       second_count_ff, second_count_in;
   logic            overflow_ff, overflow_in;
   logic            emit_ff;

   logic            accept;
   logic            first_wr_en;
   logic            second_wr_en;
   idx_type         first_rd_addr;
   idx_type         elem_pos;
   elem_type        first_rd_data;
   elem_type        second_rd_data;
   count_type       row_rd_data;
   logic            row_wr_en;
   cell_result_type cell_out;
   logic            no_elements;
   logic            last_elem;
   logic            last_col;
   logic            last_row;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Store writes on load beats that find room.
   assign first_wr_en  = accept && (req_data.cmd == CMD_FIRST)
                         && (first_count_ff < count_type'(MAX_LEN));
   assign second_wr_en = accept && (req_data.cmd == CMD_SECOND)
                         && (second_count_ff < count_type'(MAX_LEN));

   // Position in the first store of the element being emitted.
   assign elem_pos = idx_type'(count_type'(end_ff) + count_type'(elem_ff)
                               + count_type'(1) - best_ff);

   assign first_rd_addr = (state_ff == ST_EL_READ) ? elem_pos : row_ff;

   lcs_ram #(
      .DATA_BITS(ELEM_BITS),
      .ADDR_BITS(IDX_BITS)
   ) u_first_store (
      .clock  (clock),
      .wr_en  (first_wr_en),
      .wr_addr(first_count_ff[IDX_BITS-1:0]),
      .wr_data(req_data.value[ELEM_BITS-1:0]),
      .rd_addr(first_rd_addr),
      .rd_data(first_rd_data)
   );

   lcs_ram #(
      .DATA_BITS(ELEM_BITS),
      .ADDR_BITS(IDX_BITS)
   ) u_second_store (
      .clock  (clock),
      .wr_en  (second_wr_en),
      .wr_addr(second_count_ff[IDX_BITS-1:0]),
      .wr_data(req_data.value[ELEM_BITS-1:0]),
      .rd_addr(col_ff),
      .rd_data(second_rd_data)
   );

   // Row RAM: entry c holds the run length ending at column c of the row.
   assign row_wr_en = (state_ff == ST_CALC);

   lcs_ram #(
      .DATA_BITS(CNT_BITS),
      .ADDR_BITS(IDX_BITS)
   ) u_row (
      .clock  (clock),
      .wr_en  (row_wr_en),
      .wr_addr(col_ff),
      .wr_data(cell_out.len),
      .rd_addr(col_ff),
      .rd_data(row_rd_data)
   );

   // Shared compare and length unit.
   lcs_cell_unit u_cell (
      .first_elem (first_rd_data),
      .second_elem(second_rd_data),
      .diag       (diag_ff),
      .above      (row_rd_data),
      .top_row    (row_ff == '0),
      .best       (best_ff),
      .result     (cell_out)
   );

   assign last_col    = (count_type'(col_ff) + count_type'(1)) == second_count_ff;
   assign last_row    = (count_type'(row_ff) + count_type'(1)) == first_count_ff;
   assign no_elements = !emit_ff || (best_ff == '0);
   assign last_elem   = (count_type'(elem_ff) + count_type'(1)) == best_ff;

   // Sequencer and load handling.
   always_comb begin
      state_in        = state_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      elem_in         = elem_ff;
      best_in         = best_ff;
      end_in          = end_ff;
      diag_in         = diag_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      overflow_in     = overflow_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_FIRST: begin
                     if (first_wr_en) begin
                        first_count_in = first_count_ff + count_type'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  CMD_SECOND: begin
                     if (second_wr_en) begin
                        second_count_in = second_count_ff + count_type'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  CMD_COMPUTE: begin
                     row_in  = '0;
                     col_in  = '0;
                     elem_in = '0;
                     best_in = '0;
                     end_in  = '0;
                     diag_in = '0;
                     if ((first_count_ff == '0) || (second_count_ff == '0)) begin
                        state_in = ST_SUMMARY;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            // Old value of this column becomes the next column's diagonal.
            diag_in = cell_out.carry;
            if (cell_out.better) begin
               best_in = cell_out.len;
               end_in  = row_ff;
            end
            if (last_col) begin
               col_in  = '0;
               diag_in = '0;
               if (last_row) begin
                  state_in = ST_SUMMARY;
               end else begin
                  row_in   = row_ff + idx_type'(1);
                  state_in = ST_READ;
               end
            end else begin
               col_in   = col_ff + idx_type'(1);
               state_in = ST_READ;
            end
         end
         ST_SUMMARY: begin
            if (no_elements) begin
               first_count_in  = '0;
               second_count_in = '0;
               state_in        = ST_IDLE;
            end else begin
               state_in = ST_EL_READ;
            end
         end
         ST_EL_READ: begin
            state_in = ST_EL_OUT;
         end
         ST_EL_OUT: begin
            if (last_elem) begin
               first_count_in  = '0;
               second_count_in = '0;
               state_in        = ST_IDLE;
            end else begin
               elem_in  = elem_ff + idx_type'(1);
               state_in = ST_EL_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         overflow_ff     <= 1'b0;
         emit_ff         <= 1'b1;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         overflow_ff     <= overflow_in;
         if (csr_write_enable) begin
            emit_ff <= csr_write_data;
         end
      end
   end

   // Work registers.
   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      col_ff  <= col_in;
      elem_ff <= elem_in;
      best_ff <= best_in;
      end_ff  <= end_in;
      diag_ff <= diag_in;
   end

   // Result beat.
   assign rsp_strobe = (state_ff == ST_SUMMARY) || (state_ff == ST_EL_OUT);

   always_comb begin
      rsp_data.match_length = best_ff;
      rsp_data.end_index    = end_ff;
      rsp_data.overflow     = overflow_ff;
      if (state_ff == ST_EL_OUT) begin
         rsp_data.kind    = KIND_ELEMENT;
         rsp_data.element = 32'(first_rd_data);
         rsp_data.last    = last_elem;
      end else begin
         rsp_data.kind    = KIND_SUMMARY;
         rsp_data.element = '0;
         rsp_data.last    = no_elements;
      end
   end

`ifndef SYNTHESIS
   // A result beat only appears while a compute is in progress.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result beat while idle");

   // Element beats only follow a nonzero match.
   a_elem_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.kind == KIND_ELEMENT)) |-> (rsp_data.match_length != '0))
      else $error("element beat with zero match length");

   // The last beat of a compute returns the block to idle with empty stores.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last) |=> (!busy && (first_count_ff == '0)
                                         && (second_count_ff == '0)))
      else $error("block not idle after last beat");

   // Fill counts never pass the store depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (first_count_ff <= count_type'(MAX_LEN)) && (second_count_ff <= count_type'(MAX_LEN)))
      else $error("fill count beyond store depth");
`endif

endmodule
`default_nettype wire

// File: bench/longest_common_substring_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_common_substring_core_tb: self-checking bench of the LCS core
// Loads pairs of element lists and runs compute beats on them. Each accepted
// request beat also goes to an in-bench dynamic program that predicts the
// summary and element beats. A directed table comes first. A random part
// follows with small alphabets so that long runs and ties are frequent. The
// request side sees random gaps, and the emit mode is switched while the core idles.
// ----------------------------------------------------------------------------
module longest_common_substring_core_tb;
   import lcs_pkg::*;

   // The command code that the core ignores.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Longest silent stretch is a 32 x 32 compute.
   localparam int WATCHDOG_LIMIT = 12000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 8;
   localparam int RANDOM_ITEMS   = 150;
   localparam int OVERFLOW_AFTER = 110;

   localparam rsp_type EMPTY_SUMMARY = '{kind: KIND_SUMMARY, match_length: 6'd0,
                                         end_index: 5'd0, element: 32'sd0,
                                         overflow: 1'b0, last: 1'b1};

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   // One row of the directed table; typed rows carry their own expectation.
   typedef struct packed {
      row_kind_type       op;
      logic [1:0]         cmd;
      logic signed [31:0] value;
      logic               typed;
      rsp_type            typed_rsp;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_write_enable;
   logic    csr_write_data;

   // Predictor state: both lists, their fill levels, the sticky flag, the mode.
   elem_type first_seq [MAX_LEN];
   elem_type second_seq [MAX_LEN];
   int       first_len;
   int       second_len;
   logic     overflow_seen;
   logic     emit_mode;
   rsp_type  predicted [0:MAX_LEN];

   rsp_type      expected_rsp [$];
   stim_row_type directed_rows [$];
   int           fail_count;
   int           silent_cycles;

   longest_common_substring_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one request beat to the predictor and return how many result
   // beats it causes; the beats land in predicted[].
   function automatic int predict_beat(input req_type beat);
      int row_len [0:MAX_LEN];
      int best;
      int best_end;
      int run_len;
      int i;
      int j;
      case (beat.cmd)
         CMD_FIRST: begin
            if (first_len < MAX_LEN) begin
               first_seq[first_len] = beat.value;
               first_len++;
            end else begin
               overflow_seen = 1'b1;
            end
            return 0;
         end
         CMD_SECOND: begin
            if (second_len < MAX_LEN) begin
               second_seq[second_len] = beat.value;
               second_len++;
            end else begin
               overflow_seen = 1'b1;
            end
            return 0;
         end
         CMD_COMPUTE: begin
            for (j = 0; j <= MAX_LEN; j++) row_len[j] = 0;
            best     = 0;
            best_end = 0;
            // Walk the second list backward so row_len[j-1] is still the row above.
            for (i = 0; i < first_len; i++) begin
               for (j = second_len; j > 0; j--) begin
                  if (first_seq[i] == second_seq[j-1]) begin
                     row_len[j] = row_len[j-1] + 1;
                     // A strict compare keeps the earliest end index on ties.
                     if (row_len[j] > best) begin
                        best     = row_len[j];
                        best_end = i;
                     end
                  end else begin
                     row_len[j] = 0;
                  end
               end
            end
            run_len = (emit_mode && best > 0) ? best : 0;
            predicted[0] = '{kind: KIND_SUMMARY, match_length: 6'(best),
                             end_index: 5'(best_end), element: 32'sd0,
                             overflow: overflow_seen, last: (run_len == 0)};
            for (i = 0; i < run_len; i++) begin
               predicted[i+1] = '{kind: KIND_ELEMENT, match_length: 6'(best),
                                  end_index: 5'(best_end),
                                  element: first_seq[best_end + 1 - best + i],
                                  overflow: overflow_seen, last: (i + 1 == run_len)};
            end
            first_len  = 0;
            second_len = 0;
            return run_len + 1;
         end
         default: return 0;
      endcase
   endfunction

   // None when quiet; else mostly back to back, sometimes a short gap, rarely a long pause.
   function automatic int unsigned pick_gap(input bit quiet);
      int unsigned roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Present one request beat, hold it until taken, then record its results.
   task automatic drive_beat(input logic [1:0] beat_cmd, input logic [31:0] beat_value,
                             input int unsigned gap, input logic typed,
                             input rsp_type typed_rsp);
      req_type beat;
      int      n;
      beat.cmd   = beat_cmd;
      beat.value = beat_value;
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy !== 1'b0);
      n = predict_beat(beat);
      if (typed) begin
         expected_rsp.push_back(typed_rsp);
      end else begin
         for (int k = 0; k < n; k++) expected_rsp.push_back(predicted[k]);
      end
   endtask

   // Let the core drain completely, then write the emit mode.
   task automatic write_emit_mode(input logic mode);
      @(negedge clock);
      start <= 1'b0;
      while (expected_rsp.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      emit_mode = mode;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         if (expected_rsp.size() == 0) begin
            $error("result beat with no expectation waiting");
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, rsp_data.kind);
               fail_count++;
            end
            if (rsp_data.match_length !== want.match_length) begin
               $error("match_length: expected %0d, actual %0d",
                      want.match_length, rsp_data.match_length);
               fail_count++;
            end
            if (rsp_data.end_index !== want.end_index) begin
               $error("end_index: expected %0d, actual %0d",
                      want.end_index, rsp_data.end_index);
               fail_count++;
            end
            if (rsp_data.element !== want.element) begin
               $error("element: expected %0d, actual %0d", want.element, rsp_data.element);
               fail_count++;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $error("overflow: expected %0d, actual %0d",
                      want.overflow, rsp_data.overflow);
               fail_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_data.last);
               fail_count++;
            end
         end
      end
   end

   // End the run when no beat moves in either direction for too long.
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1) begin
         silent_cycles <= 0;
      end else if (silent_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("longest_common_substring_core verification failed");
         $finish;
      end else begin
         silent_cycles <= silent_cycles + 1;
      end
   end

   initial begin
      int unsigned  n_first;
      int unsigned  n_second;
      int unsigned  alpha_size;
      int           item_count;
      bit           quiet;
      logic [1:0]   next_cmd;
      logic [31:0]  code;
      elem_type     alphabet [4];
      stim_row_type row;

      reset            = 1'b1;
      start            = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      first_len        = 0;
      second_len       = 0;
      overflow_seen    = 1'b0;
      emit_mode        = 1'b1;
      fail_count       = 0;
      silent_cycles    = 0;
      item_count       = 0;

      // Directed table: empty compute after reset, field extremes with a tie,
      // the ignored command, one empty list, no match, and the summary-only mode.
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_COMPUTE, 32'sd0, 1'b1, EMPTY_SUMMARY});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_FIRST, 32'sh8000_0000, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_FIRST, 32'sh7FFF_FFFF, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_UNUSED, 32'sh5A5A_A5A5, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_FIRST, 32'sd0, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_FIRST, -32'sd1, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_SECOND, -32'sd1, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_SECOND, 32'sh7FFF_FFFF, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_SECOND, 32'sh8000_0000, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_COMPUTE, 32'sh1234_5678, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_SECOND, 32'sd7, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_COMPUTE, 32'sd0, 1'b1, EMPTY_SUMMARY});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_FIRST, 32'sd1, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_SECOND, 32'sd2, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_COMPUTE, 32'sd0, 1'b1, EMPTY_SUMMARY});
      directed_rows.push_back(stim_row_type'{ROW_CSR, CMD_FIRST, 32'sd0, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_FIRST, 32'sd5, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_FIRST, 32'sd6, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_SECOND, 32'sd9, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_SECOND, 32'sd5, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_SECOND, 32'sd6, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_BEAT, CMD_COMPUTE, -32'sd1, 1'b0, '0});
      directed_rows.push_back(stim_row_type'{ROW_CSR, CMD_FIRST, 32'sd1, 1'b0, '0});

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.op == ROW_CSR) begin
            write_emit_mode(row.value[0]);
         end else begin
            drive_beat(row.cmd, row.value, pick_gap(1'b0), row.typed, row.typed_rsp);
         end
      end

      // Random part: well-formed load sets over a small alphabet, each closed
      // by a compute, with stray codes and ignored beats mixed in.
      while (item_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) write_emit_mode(1'($urandom_range(0, 1)));
         quiet      = ($urandom_range(0, 2) == 0);
         alpha_size = $urandom_range(1, 4);
         if (!overflow_seen && item_count >= OVERFLOW_AFTER) begin
            // Overrun the first store; the second may or may not overrun too.
            n_first  = MAX_LEN + $urandom_range(1, 2);
            n_second = $urandom_range(0, MAX_LEN + 1);
         end else if ($urandom_range(0, 11) == 0) begin
            n_first    = MAX_LEN;
            n_second   = MAX_LEN;
            alpha_size = $urandom_range(1, 2);
         end else begin
            n_first  = $urandom_range(0, 8);
            n_second = $urandom_range(0, 8);
         end
         foreach (alphabet[a]) begin
            case ($urandom_range(0, 11))
               0:       alphabet[a] = 32'h8000_0000;
               1:       alphabet[a] = 32'h7FFF_FFFF;
               2:       alphabet[a] = 32'h0000_0000;
               3:       alphabet[a] = 32'hFFFF_FFFF;
               default: alphabet[a] = $urandom;
            endcase
         end
         while (n_first + n_second > 0) begin
            if ($urandom_range(0, 14) == 0) begin
               drive_beat(CMD_UNUSED, $urandom, pick_gap(quiet), 1'b0, '0);
            end
            if (n_second == 0 || (n_first > 0 && $urandom_range(0, 1) == 1)) begin
               next_cmd = CMD_FIRST;
               n_first--;
            end else begin
               next_cmd = CMD_SECOND;
               n_second--;
            end
            code = ($urandom_range(0, 9) == 0) ? $urandom
                                               : alphabet[$urandom_range(0, alpha_size - 1)];
            drive_beat(next_cmd, code, pick_gap(quiet), 1'b0, '0);
            item_count++;
         end
         drive_beat(CMD_COMPUTE, $urandom, pick_gap(quiet), 1'b0, '0);
         item_count++;
      end

      @(negedge clock);
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("longest_common_substring_core verification clean");
      end else begin
         $display("longest_common_substring_core verification failed");
      end
      $finish;
   end

endmodule

// File: longest_common_substring_core.f
hdl/lcs_pkg.sv
hdl/lcs_ram.sv
hdl/lcs_cell_unit.sv
hdl/longest_common_substring_core.sv
bench/longest_common_substring_core_tb.sv
